[rtl/sss_pkg.sv]
// Shared types and constants for the smooth scroll stepper.
package sss_pkg;

  // Fixed-point format and view count
  localparam int NUM_VIEWS  = 16;
  localparam int FRAC_BITS  = 8;
  localparam int VIEW_W     = 4;
  localparam int POS_W      = 32;
  localparam int VEL_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [VEL_W-1:0] ONE_FIX = VEL_W'(1) << FRAC_BITS;

  // Register reset values
  localparam logic [3:0]  GAIN_SHIFT_RST  = 4'd1;
  localparam logic [7:0]  SPEED_MULT_RST  = 8'd80;
  localparam logic [15:0] SNAP_WINDOW_RST = 16'd26;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_SHIFT  = 2'd0,
    CFG_SPEED_MULT  = 2'd1,
    CFG_SNAP_WINDOW = 2'd2
  } cfg_reg_t;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  typedef struct packed {
    logic [VIEW_W-1:0]       view_index;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [POS_W-1:0] scroll_x_in;
    logic signed [POS_W-1:0] scroll_y_in;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] scroll_x_out;
    logic signed [POS_W-1:0] scroll_y_out;
    logic                    changed;
  } out_item_t;

  // One axis step: new position, new velocity, moved flag
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [VEL_W-1:0]        vel;
    logic                    moved;
  } axis_res_t;

endpackage

[rtl/smooth_scroll_stepper.sv]
// Smooth scroll stepper top level: per-view velocity state and one-pass axis stepping.
//
//   channel  ports                                  direction  beat
//   input    in_valid / in_ready / in_data           in         one view tick
//   result   out_valid / out_ready / out_data        out        new positions, changed
//   config   cfg_valid / cfg_ready / cfg_index+data  in         one register write
//
// An accepted beat lands in the input register; from there the axis logic and the velocity
// multiplier compute the result and velocity update in one pass into the result register,
// so one beat per cycle flows through while the result register is not stalled by out_ready.
// A stalled result register holds the input register; velocities of a view are written
// as its beat moves on, so the following beat for that view sees the update.
// Synchronous active-low reset clears all velocities and loads register defaults.
module smooth_scroll_stepper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sss_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sss_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  sss_pkg::cfg_index_t               cfg_index,
  input  logic [sss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sss_pkg::*;

  logic [3:0]        gain_shift_r;
  logic [7:0]        speed_mult_r;
  logic [15:0]       snap_window_r;

  logic [VEL_W-1:0]  vel_x_r [NUM_VIEWS];
  logic [VEL_W-1:0]  vel_y_r [NUM_VIEWS];

  logic              s1_valid_r;
  in_item_t          s1_data_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              s1_adv;
  logic              view_ok;
  logic [VEL_W-1:0]  vx_cur;
  logic [VEL_W-1:0]  vy_cur;
  logic              vel_init;
  axis_res_t         res_x;
  axis_res_t         res_y;
  out_item_t         out_nxt;

  // Step one axis toward its target
  function automatic axis_res_t axis_step(
    input logic signed [POS_W-1:0] tgt,
    input logic signed [POS_W-1:0] cur,
    input logic [VEL_W-1:0]        vel,
    input logic [3:0]              shift,
    input logic [7:0]              mult,
    input logic [15:0]             snap
  );
    logic [POS_W:0]       diff;
    logic                 down;
    logic [POS_W:0]       mag;
    logic [POS_W:0]       approach;
    logic                 vel_sel;
    logic [VEL_W+7:0]     prod;
    logic [POS_W-1:0]     step;
    logic [POS_W+1:0]     sum;
    axis_res_t            res;
    diff     = {tgt[POS_W-1], tgt} - {cur[POS_W-1], cur};
    down     = diff[POS_W];
    mag      = down ? (~diff + (POS_W+1)'(1)) : diff;
    approach = mag >> shift;
    vel_sel  = ({1'b0, vel} <= approach);
    prod     = (VEL_W+8)'(vel) * (VEL_W+8)'(mult);
    step     = vel_sel ? vel : approach[POS_W-1:0];
    sum      = down ? ({{2{cur[POS_W-1]}}, cur} - {2'b00, step})
                    : ({{2{cur[POS_W-1]}}, cur} + {2'b00, step});
    res.pos   = cur;
    res.vel   = vel;
    res.moved = 1'b0;
    if (diff != '0) begin
      res.moved = 1'b1;
      if (mag < {{(POS_W+1-16){1'b0}}, snap}) begin
        res.pos = tgt;
        res.vel = ONE_FIX;
      end else begin
        // Position stays between current and target, so the low bits are exact
        res.pos = sum[POS_W-1:0];
        if (vel_sel) begin
          res.vel = (prod[VEL_W+7:VEL_W] != '0) ? '1 : prod[VEL_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_shift_r  <= GAIN_SHIFT_RST;
      speed_mult_r  <= SPEED_MULT_RST;
      snap_window_r <= SNAP_WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_SHIFT:  gain_shift_r  <= cfg_data[3:0];
        CFG_SPEED_MULT:  speed_mult_r  <= cfg_data[7:0];
        CFG_SNAP_WINDOW: snap_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input register advances whenever the result register frees up
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Read velocities of the view; a zero x velocity starts both at 1.0
  assign view_ok  = (32'(s1_data_r.view_index) < NUM_VIEWS);
  assign vel_init = (vel_x_r[s1_data_r.view_index] == '0);
  assign vx_cur   = vel_init ? ONE_FIX : vel_x_r[s1_data_r.view_index];
  assign vy_cur   = vel_init ? ONE_FIX : vel_y_r[s1_data_r.view_index];

  always_comb begin
    res_x = axis_step(s1_data_r.goal_x, s1_data_r.scroll_x_in, vx_cur,
                      gain_shift_r, speed_mult_r, snap_window_r);
    res_y = axis_step(s1_data_r.goal_y, s1_data_r.scroll_y_in, vy_cur,
                      gain_shift_r, speed_mult_r, snap_window_r);
  end

  always_comb begin
    out_nxt.scroll_x_out = view_ok ? res_x.pos : s1_data_r.scroll_x_in;
    out_nxt.scroll_y_out = view_ok ? res_y.pos : s1_data_r.scroll_y_in;
    out_nxt.changed      = view_ok && (res_x.moved || res_y.moved);
  end

  // Write back velocities as the beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VIEWS; i++) begin
        vel_x_r[i] <= '0;
        vel_y_r[i] <= '0;
      end
    end else if (s1_valid_r && s1_adv && view_ok) begin
      vel_x_r[s1_data_r.view_index] <= res_x.vel;
      vel_y_r[s1_data_r.view_index] <= res_y.vel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/sss_checker.sv]
// Port-level checks for the smooth scroll stepper, bound to the top level.
module sss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input sss_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input sss_pkg::out_item_t             out_data
);
  import sss_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An empty result side never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Hold a stalled input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat dropped or changed while stalled");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

endmodule

bind smooth_scroll_stepper sss_checker u_sss_checker (.*);
